>>> hdl/ttyop_pkg.sv
// Package for the terminal output post-processor: beat layouts, register
// indexes, function codes and character constants.
// No dependencies; imported by ttyop_core and tty_output_post_processor_unit.
package ttyop_pkg;

	localparam int COL_W = 12;
	localparam logic [COL_W-1:0] COL_MAX = 12'hFFF;

	localparam logic [2:0] REG_POST_ENABLE     = 3'd0;
	localparam logic [2:0] REG_NEWLINE_TO_CRLF = 3'd1;
	localparam logic [2:0] REG_LOWER_TO_UPPER  = 3'd2;
	localparam logic [2:0] REG_CARET_ECHO      = 3'd3;
	localparam logic [2:0] REG_EOF_CHAR        = 3'd4;
	localparam logic [2:0] REG_WINDOW_COLS     = 3'd5;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_ECHO  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_VT_CR_LAST = 8'h0D;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

	typedef struct packed {
		logic             post_enable;
		logic             newline_to_crlf;
		logic             lower_to_upper;
		logic             caret_echo;
		logic [7:0]       eof_char;
		logic [COL_W-1:0] window_cols;
	} cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_in;
		logic       escaped;
		logic [1:0] queue_room;
	} item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_valid;
		logic             last;
		logic             refused;
		logic [COL_W-1:0] column_now;
	} result_t;

	typedef struct packed {
		result_t          first;
		logic             two;
		logic [7:0]       second_byte;
		logic [COL_W-1:0] next_col;
	} step_t;

endpackage

>>> hdl/tty_output_post_processor_unit.sv
// Top level of the terminal output post-processor: input register, cursor and
// configuration registers, result register with a second-beat holding stage.
// Depends on ttyop_pkg and ttyop_core.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata, tuser (character, mode)
//   m_axis    out        m_axis_tvalid/tready       tdata, tuser, tlast (bytes)
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A character is registered on entry, decoded by ttyop_core once the result
// register can take it, and its first output beat is registered there.
// A new character is accepted every cycle while the output is not stalled; one
// that emits two bytes holds the processing stage while its second beat goes out.
// Reset clears the column to zero and loads the configuration defaults.
// A stalled output holds its beat and backs up into the input register.
module tty_output_post_processor_unit #(
	parameter int TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Bits from 0: char_in[7:0], escaped[8], queue_room[10:9], zero fill.
	input  logic [15:0] s_axis_tdata,
	// Bits from 0: func[1:0].
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Bits from 0: out_byte[7:0], column_now[19:8], zero fill.
	output logic [23:0] m_axis_tdata,
	// Bits from 0: out_valid[0], refused[1].
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import ttyop_pkg::*;

	item_t            item_s1;
	logic             valid_s1;
	cfg_t             cfg_q;
	logic [COL_W-1:0] cursor_q;
	result_t          out_q;
	logic             out_v_q;
	logic             sec_v_q;
	logic [7:0]       sec_byte_q;
	step_t            step;
	logic             fire;
	logic             out_taken;

	ttyop_core #(
		.TAB_WIDTH(TAB_WIDTH)
	) u_core (
		.cfg  (cfg_q),
		.item (item_s1),
		.col  (cursor_q),
		.step (step)
	);

	assign out_taken = out_v_q && m_axis_tready;
	assign fire = valid_s1 && !sec_v_q && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'b0, out_q.column_now, out_q.out_byte};
	assign m_axis_tuser = {out_q.refused, out_q.out_valid};
	assign m_axis_tlast = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q <= 1'b0;
			sec_v_q <= 1'b0;
			cursor_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (fire) begin
				out_v_q <= 1'b1;
				sec_v_q <= step.two;
				cursor_q <= step.next_col;
			end else if (out_taken) begin
				out_v_q <= sec_v_q;
				sec_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func <= s_axis_tuser;
			item_s1.char_in <= s_axis_tdata[7:0];
			item_s1.escaped <= s_axis_tdata[8];
			item_s1.queue_room <= s_axis_tdata[10:9];
		end
		if (fire) begin
			out_q <= step.first;
			sec_byte_q <= step.second_byte;
		end else if (out_taken && sec_v_q) begin
			out_q.out_byte <= sec_byte_q;
			out_q.out_valid <= 1'b1;
			out_q.last <= 1'b1;
			out_q.refused <= 1'b0;
			out_q.column_now <= cursor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.post_enable <= 1'b1;
			cfg_q.newline_to_crlf <= 1'b1;
			cfg_q.lower_to_upper <= 1'b0;
			cfg_q.caret_echo <= 1'b1;
			cfg_q.eof_char <= 8'd4;
			cfg_q.window_cols <= 12'd80;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POST_ENABLE:     cfg_q.post_enable <= cfg_data[0];
				REG_NEWLINE_TO_CRLF: cfg_q.newline_to_crlf <= cfg_data[0];
				REG_LOWER_TO_UPPER:  cfg_q.lower_to_upper <= cfg_data[0];
				REG_CARET_ECHO:      cfg_q.caret_echo <= cfg_data[0];
				REG_EOF_CHAR:        cfg_q.eof_char <= cfg_data[7:0];
				REG_WINDOW_COLS:     cfg_q.window_cols <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

>>> hdl/ttyop_core.sv
// Combinational step of the output post-processor: decodes one character
// against the configuration and the cursor column, giving up to two beats.
// Depends on ttyop_pkg.
module ttyop_core #(
	parameter int TAB_WIDTH = 8
) (
	input  ttyop_pkg::cfg_t                  cfg,
	input  ttyop_pkg::item_t                 item,
	input  logic [ttyop_pkg::COL_W-1:0]      col,
	output ttyop_pkg::step_t                 step
);
	import ttyop_pkg::*;

	// The column is divided by the tab width through a reciprocal multiply;
	// this shift keeps the quotient exact over the whole column range.
	localparam int DIV_SHIFT = COL_W + $clog2(TAB_WIDTH);
	localparam int MULT_W = DIV_SHIFT + 1;
	localparam int PROD_W = COL_W + MULT_W;
	localparam logic [MULT_W-1:0] DIV_MULT =
		MULT_W'((2 ** DIV_SHIFT + TAB_WIDTH - 1) / TAB_WIDTH);

	logic [7:0]       ch;
	logic             is_ctrl;
	logic             is_space;
	logic             caret_path;
	logic [COL_W-1:0] col_inc1;
	logic [COL_W-1:0] col_inc2;
	logic [COL_W-1:0] cap;
	logic [PROD_W-1:0] prod;
	logic [COL_W-1:0] quot;
	logic [COL_W:0]   tab_next;
	logic [COL_W-1:0] tab_col;
	logic [7:0]       pp_byte;
	logic             pp_two;
	logic [COL_W-1:0] pp_col;
	logic             emit;
	logic [7:0]       em_byte;
	logic [7:0]       em_second;
	logic             em_two;
	logic [COL_W-1:0] em_col;
	logic             fits;

	assign ch = item.char_in;
	assign is_ctrl = (ch < CH_SPACE) || (ch == CH_DEL);
	assign is_space = (ch inside {[CH_TAB:CH_VT_CR_LAST]}) || (ch == CH_SPACE);
	assign caret_path = (func_t'(item.func) == FUNC_ECHO) && is_ctrl && !is_space
		&& cfg.caret_echo;

	assign col_inc1 = (col == COL_MAX) ? COL_MAX : col + 1'b1;
	assign col_inc2 = (col >= COL_MAX - 1'b1) ? COL_MAX : col + 2'd2;

	assign cap = cfg.window_cols - 1'b1;
	assign prod = PROD_W'(col) * PROD_W'(DIV_MULT);
	assign quot = prod[DIV_SHIFT +: COL_W];
	assign tab_next = ({1'b0, quot} + 1'b1) * (COL_W+1)'(TAB_WIDTH);

	always_comb begin
		tab_col = col;
		if (cfg.window_cols != '0 && col < cap) begin
			tab_col = (tab_next < {1'b0, cap}) ? tab_next[COL_W-1:0] : cap;
		end
	end

	always_comb begin
		pp_byte = ch;
		pp_two = 1'b0;
		pp_col = col;
		if (!cfg.post_enable) begin
			pp_col = col;
		end else if (ch == CH_LF) begin
			if (cfg.newline_to_crlf) begin
				pp_byte = CH_CR;
				pp_two = 1'b1;
				pp_col = '0;
			end
		end else if (ch == CH_TAB) begin
			pp_col = tab_col;
		end else if (ch == CH_BS) begin
			pp_col = (col != '0) ? col - 1'b1 : col;
		end else begin
			if (cfg.lower_to_upper && (ch inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
				pp_byte = ch - CASE_OFFSET;
			end
			if (!is_ctrl) begin
				pp_col = col_inc1;
			end
		end
	end

	always_comb begin
		emit = 1'b1;
		em_byte = pp_byte;
		em_second = CH_LF;
		em_two = pp_two;
		em_col = pp_col;
		if (caret_path) begin
			if (!item.escaped && ch == cfg.eof_char) begin
				emit = 1'b0;
			end else begin
				em_byte = CH_CARET;
				em_second = ch + CARET_OFFSET;
				em_two = 1'b1;
				em_col = col_inc2;
			end
		end
	end

	assign fits = em_two ? item.queue_room[1] : (item.queue_room != 2'd0);

	always_comb begin
		step.first.out_byte = '0;
		step.first.out_valid = 1'b0;
		step.first.last = 1'b1;
		step.first.refused = 1'b0;
		step.first.column_now = col;
		step.two = 1'b0;
		step.second_byte = em_second;
		step.next_col = col;
		case (func_t'(item.func))
			FUNC_CLEAR: begin
				step.next_col = '0;
				step.first.column_now = '0;
			end
			FUNC_WRITE, FUNC_ECHO: begin
				if (emit) begin
					if (!fits) begin
						step.first.refused = (func_t'(item.func) == FUNC_WRITE);
					end else begin
						step.next_col = em_col;
						step.first.out_byte = em_byte;
						step.first.out_valid = 1'b1;
						step.first.last = !em_two;
						step.first.column_now = em_col;
						step.two = em_two;
					end
				end
			end
			default: begin
				step.next_col = col;
			end
		endcase
	end

endmodule
